// File: design/gesd_pkg.sv
// Package for the gyro energy stance detector.
// Holds the beat types of both channels, register indexes and opcodes.
// No dependencies.
package gesd_pkg;

    // Configuration port geometry: 64-bit data, registers at 8-byte spacing.
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 64;

    localparam logic [0:0] REG_ENERGY_THRESHOLD = 1'b0;
    localparam logic [0:0] REG_HOLD_COUNT       = 1'b1;

    localparam logic [35:0] THRESHOLD_RESET  = 36'd1000000;
    localparam logic [7:0]  HOLD_COUNT_RESET = 8'd5;

    localparam logic [35:0] ENERGY_MAX = 36'hF_FFFF_FFFF;
    localparam logic [7:0]  HOLD_MAX   = 8'hFF;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_PRIME  = 1'b1;

    localparam logic PHASE_STANCE = 1'b0;
    localparam logic PHASE_SWING  = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [15:0] gyro_a_x;
        logic signed [15:0] gyro_a_y;
        logic signed [15:0] gyro_a_z;
        logic signed [15:0] gyro_b_x;
        logic signed [15:0] gyro_b_y;
        logic signed [15:0] gyro_b_z;
    } sample_t;

    typedef struct packed {
        logic               phase;
        logic        [7:0]  hold_counter;
        logic signed [15:0] mean_rate_x;
        logic signed [15:0] mean_rate_y;
        logic signed [15:0] mean_rate_z;
        logic        [35:0] window_energy;
    } result_t;

endpackage

// File: design/gyro_energy_stance_detector_top.sv
// Channel   | Dir | Handshake                   | Beat
// ----------+-----+-----------------------------+--------------------------------
// sample    | in  | sample_valid / sample_stall | gesd_pkg::sample_t (op, 2x3 rates)
// result    | out | result_valid / result_stall | gesd_pkg::result_t (phase, means, energy)
// config    | in  | APB psel/penable/pwrite     | 64-bit registers at 8*index
//
// One beat is accepted per cycle while sample_stall is low. Each accepted sample beat
// yields one result beat: stage 1 updates the rate ring and running sums and forms the
// clamped mean, stage 2 squares the three means, stage 3 updates the energy window and
// the hysteresis phase and loads the result register. Stalls move back stage by stage; a
// stage that holds a beat accepts a new one in the cycle its own beat moves on. Reset
// clears all control state at once; ring and energy memories need no clearing pass since
// per-entry valid bits make an unwritten entry read as its reset or primed value.
//
// Top level of the gyro energy stance detector (zero-velocity-update detector).
// Depends on gesd_pkg.
module gyro_energy_stance_detector_top #(
    parameter int RATE_WINDOW   = 8,
    parameter int ENERGY_WINDOW = 16,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  gesd_pkg::sample_t              sample,

    output logic                           result_valid,
    input  logic                           result_stall,
    output gesd_pkg::result_t              result,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gesd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [gesd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [gesd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    // Ring pointer, running sum and mean geometry.
    localparam int RP_W   = $clog2(RATE_WINDOW);
    localparam int EP_W   = $clog2(ENERGY_WINDOW);
    localparam int SUM_W  = 17 + $clog2(RATE_WINDOW);
    // floor(log2(2*RATE_WINDOW)): averages over the ring and the two IMUs
    localparam int SHIFT  = $clog2(RATE_WINDOW + 1);
    localparam int MEAN_B = (SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS;
    localparam int ESUM_RAW_W = 32 + $clog2(ENERGY_WINDOW);
    localparam int ESUM_W = (ESUM_RAW_W > 36) ? ESUM_RAW_W : 36;

    localparam logic signed [SUM_W-1:0] RW_S    = SUM_W'(RATE_WINDOW);
    localparam logic signed [SUM_W-1:0] MEAN_HI = SUM_W'((1 << (MEAN_B - 1)) - 1);
    localparam logic signed [SUM_W-1:0] MEAN_LO = -MEAN_HI - SUM_W'(1);
    localparam logic [RP_W-1:0] RP_LAST = RP_W'(RATE_WINDOW - 1);
    localparam logic [EP_W-1:0] EP_LAST = EP_W'(ENERGY_WINDOW - 1);
    localparam logic [ESUM_W-1:0] ESUM_MAX = ESUM_W'(gesd_pkg::ENERGY_MAX);

    typedef struct packed {
        logic                    prime;
        logic [2:0][15:0]        mean;
    } s1_beat_t;

    typedef struct packed {
        logic                    prime;
        logic [2:0][15:0]        mean;
        logic [31:0]             mag;
    } s2_beat_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [35:0]  threshold_reg, threshold_next;
    logic [7:0]   hold_count_reg, hold_count_next;
    logic         cfg_write;
    logic [0:0]   cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[gesd_pkg::CFG_ADDR_W-1 -: 1];

    always_comb
    begin
        threshold_next  = threshold_reg;
        hold_count_next = hold_count_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                gesd_pkg::REG_ENERGY_THRESHOLD: threshold_next  = pwdata[35:0];
                gesd_pkg::REG_HOLD_COUNT:       hold_count_next = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            gesd_pkg::REG_ENERGY_THRESHOLD: prdata = {28'b0, threshold_reg};
            gesd_pkg::REG_HOLD_COUNT:       prdata = {56'b0, hold_count_reg};
            default:                        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: each stage moves when the next has room.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic result_valid_reg, result_valid_next;
    logic out_ready, s2_ready, s1_ready;
    logic accept, adv2, adv3;

    assign out_ready    = !result_valid_reg || !result_stall;
    assign adv3         = s2_valid_reg && out_ready;
    assign s2_ready     = !s2_valid_reg || out_ready;
    assign adv2         = s1_valid_reg && s2_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign sample_stall = !s1_ready;
    assign accept       = sample_valid && s1_ready;

    assign s1_valid_next     = accept || (s1_valid_reg && !adv2);
    assign s2_valid_next     = adv2 || (s2_valid_reg && !adv3);
    assign result_valid_next = adv3 || (result_valid_reg && result_stall);
    assign result_valid      = result_valid_reg;

    // ------------------------------------------------------------------
    // Stage 1: rate ring, running sums, clamped moving mean
    // ------------------------------------------------------------------
    logic [2:0][16:0]         ring_mem [RATE_WINDOW];
    logic [2:0][16:0]         ring_rd_reg;
    logic [RP_W-1:0]          ring_rd_addr;
    logic [RATE_WINDOW-1:0]   ring_valid_reg, ring_valid_next;
    logic [RP_W-1:0]          rate_ptr_reg, rate_ptr_next, rate_ptr_inc;
    logic signed [16:0]       prime_val_reg [3];
    logic signed [16:0]       prime_val_next [3];
    logic signed [SUM_W-1:0]  rate_sum_reg [3];
    logic signed [SUM_W-1:0]  rate_sum_next [3];
    logic signed [SUM_W-1:0]  sum_cand [3];
    logic signed [SUM_W-1:0]  s_ext [3];
    logic signed [SUM_W-1:0]  old_ext [3];
    logic signed [SUM_W-1:0]  shifted [3];
    logic signed [15:0]       gyro_a [3];
    logic signed [15:0]       gyro_b [3];
    logic signed [16:0]       pair_sum [3];
    logic signed [16:0]       old_val [3];
    logic [2:0][16:0]         ring_wdata;
    logic                     is_prime;
    s1_beat_t                 s1_reg, s1_next;

    assign gyro_a[0] = sample.gyro_a_x;
    assign gyro_a[1] = sample.gyro_a_y;
    assign gyro_a[2] = sample.gyro_a_z;
    assign gyro_b[0] = sample.gyro_b_x;
    assign gyro_b[1] = sample.gyro_b_y;
    assign gyro_b[2] = sample.gyro_b_z;
    assign is_prime  = (sample.op == gesd_pkg::OP_PRIME);

    assign rate_ptr_inc = (rate_ptr_reg == RP_LAST) ? '0 : rate_ptr_reg + 1'b1;

    always_comb
    begin
        s1_next         = s1_reg;
        ring_valid_next = ring_valid_reg;
        rate_ptr_next   = rate_ptr_reg;
        for (int ax = 0; ax < 3; ax++)
        begin
            pair_sum[ax]   = 17'(gyro_a[ax]) + 17'(gyro_b[ax]);
            ring_wdata[ax] = pair_sum[ax];
            // an entry not written since the last prime holds the primed value
            old_val[ax]    = ring_valid_reg[rate_ptr_reg] ? $signed(ring_rd_reg[ax])
                                                          : prime_val_reg[ax];
            s_ext[ax]      = SUM_W'(pair_sum[ax]);
            old_ext[ax]    = SUM_W'(old_val[ax]);
            sum_cand[ax]   = is_prime ? SUM_W'(s_ext[ax] * RW_S)
                                      : rate_sum_reg[ax] + s_ext[ax] - old_ext[ax];
            shifted[ax]    = sum_cand[ax] >>> SHIFT;
            rate_sum_next[ax]  = accept ? sum_cand[ax] : rate_sum_reg[ax];
            prime_val_next[ax] = (accept && is_prime) ? pair_sum[ax] : prime_val_reg[ax];
        end
        if (accept)
        begin
            s1_next.prime = is_prime;
            for (int ax = 0; ax < 3; ax++)
            begin
                if (shifted[ax] > MEAN_HI)
                begin
                    s1_next.mean[ax] = MEAN_HI[15:0];
                end
                else if (shifted[ax] < MEAN_LO)
                begin
                    s1_next.mean[ax] = MEAN_LO[15:0];
                end
                else
                begin
                    s1_next.mean[ax] = shifted[ax][15:0];
                end
            end
            if (is_prime)
            begin
                ring_valid_next = '0;
            end
            else
            begin
                ring_valid_next[rate_ptr_reg] = 1'b1;
                rate_ptr_next                 = rate_ptr_inc;
            end
        end
    end

    // prefetch the entry the next beat will retire
    assign ring_rd_addr = (accept && !is_prime) ? rate_ptr_inc : rate_ptr_reg;

    always_ff @(posedge clk)
    begin
        if (accept && !is_prime)
        begin
            ring_mem[rate_ptr_reg] <= ring_wdata;
        end
        ring_rd_reg <= ring_mem[ring_rd_addr];
    end

    // ------------------------------------------------------------------
    // Stage 2: squared magnitude of the mean vector
    // ------------------------------------------------------------------
    logic signed [31:0] sq [3];
    s2_beat_t           s2_reg, s2_next;

    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            sq[ax] = $signed(s1_reg.mean[ax]) * $signed(s1_reg.mean[ax]);
        end
        s2_next = s2_reg;
        if (adv2)
        begin
            s2_next.prime = s1_reg.prime;
            s2_next.mean  = s1_reg.mean;
            // each square is at most 2^30, so three of them fit in 32 bits
            s2_next.mag   = $unsigned(sq[0]) + $unsigned(sq[1]) + $unsigned(sq[2]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: energy window, threshold, hysteresis, result register
    // ------------------------------------------------------------------
    logic [31:0]               energy_mem [ENERGY_WINDOW];
    logic [31:0]               energy_rd_reg;
    logic [EP_W-1:0]           energy_rd_addr;
    logic [ENERGY_WINDOW-1:0]  energy_valid_reg, energy_valid_next;
    logic [EP_W-1:0]           energy_ptr_reg, energy_ptr_next, energy_ptr_inc;
    logic [ESUM_W-1:0]         energy_sum_reg, energy_sum_next;
    logic [ESUM_W-1:0]         esum_cand;
    logic [31:0]               energy_old;
    logic [35:0]               energy_sat;
    logic                      swing_seen;
    logic                      phase_reg, phase_next;
    logic [7:0]                hold_reg, hold_next;
    logic [7:0]                hold_step;
    gesd_pkg::result_t         result_reg, result_next;

    assign energy_ptr_inc = (energy_ptr_reg == EP_LAST) ? '0 : energy_ptr_reg + 1'b1;
    assign energy_old     = energy_valid_reg[energy_ptr_reg] ? energy_rd_reg : 32'd0;
    assign esum_cand      = energy_sum_reg - ESUM_W'(energy_old) + ESUM_W'(s2_reg.mag);
    assign energy_sat     = (esum_cand > ESUM_MAX) ? gesd_pkg::ENERGY_MAX : esum_cand[35:0];
    assign swing_seen     = (energy_sat >= threshold_reg);

    always_comb
    begin
        energy_valid_next = energy_valid_reg;
        energy_ptr_next   = energy_ptr_reg;
        energy_sum_next   = energy_sum_reg;
        phase_next        = phase_reg;
        hold_next         = hold_reg;
        hold_step         = hold_reg;
        result_next       = result_reg;
        if (adv3)
        begin
            if (s2_reg.prime)
            begin
                energy_valid_next = '0;
                energy_ptr_next   = '0;
                energy_sum_next   = '0;
                phase_next        = gesd_pkg::PHASE_STANCE;
                hold_next         = '0;
            end
            else
            begin
                energy_valid_next[energy_ptr_reg] = 1'b1;
                energy_ptr_next = energy_ptr_inc;
                energy_sum_next = esum_cand;
                if (swing_seen && phase_reg == gesd_pkg::PHASE_STANCE)
                begin
                    hold_step  = (hold_reg == gesd_pkg::HOLD_MAX) ? hold_reg : hold_reg + 8'd1;
                    hold_next  = hold_step;
                    phase_next = (hold_step >= hold_count_reg) ? gesd_pkg::PHASE_SWING
                                                               : gesd_pkg::PHASE_STANCE;
                end
                else if (!swing_seen && phase_reg == gesd_pkg::PHASE_SWING)
                begin
                    hold_step  = (hold_reg == 8'd0) ? hold_reg : hold_reg - 8'd1;
                    hold_next  = hold_step;
                    phase_next = (hold_step == 8'd0) ? gesd_pkg::PHASE_STANCE
                                                     : gesd_pkg::PHASE_SWING;
                end
            end
            result_next.phase         = phase_next;
            result_next.hold_counter  = hold_next;
            result_next.mean_rate_x   = s2_reg.mean[0];
            result_next.mean_rate_y   = s2_reg.mean[1];
            result_next.mean_rate_z   = s2_reg.mean[2];
            result_next.window_energy = s2_reg.prime ? 36'd0 : energy_sat;
        end
    end

    // a prime restarts the window at entry zero
    assign energy_rd_addr = adv3 ? (s2_reg.prime ? '0 : energy_ptr_inc) : energy_ptr_reg;

    always_ff @(posedge clk)
    begin
        if (adv3 && !s2_reg.prime)
        begin
            energy_mem[energy_ptr_reg] <= s2_reg.mag;
        end
        energy_rd_reg <= energy_mem[energy_rd_addr];
    end

    assign result = result_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= gesd_pkg::THRESHOLD_RESET;
            hold_count_reg   <= gesd_pkg::HOLD_COUNT_RESET;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            ring_valid_reg   <= '0;
            rate_ptr_reg     <= '0;
            for (int ax = 0; ax < 3; ax++)
            begin
                prime_val_reg[ax] <= '0;
                rate_sum_reg[ax]  <= '0;
            end
            energy_valid_reg <= '0;
            energy_ptr_reg   <= '0;
            energy_sum_reg   <= '0;
            phase_reg        <= gesd_pkg::PHASE_STANCE;
            hold_reg         <= '0;
        end
        else
        begin
            threshold_reg    <= threshold_next;
            hold_count_reg   <= hold_count_next;
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s2_valid_next;
            result_valid_reg <= result_valid_next;
            ring_valid_reg   <= ring_valid_next;
            rate_ptr_reg     <= rate_ptr_next;
            for (int ax = 0; ax < 3; ax++)
            begin
                prime_val_reg[ax] <= prime_val_next[ax];
                rate_sum_reg[ax]  <= rate_sum_next[ax];
            end
            energy_valid_reg <= energy_valid_next;
            energy_ptr_reg   <= energy_ptr_next;
            energy_sum_reg   <= energy_sum_next;
            phase_reg        <= phase_next;
            hold_reg         <= hold_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        s1_reg     <= s1_next;
        s2_reg     <= s2_next;
        result_reg <= result_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_swing_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == gesd_pkg::PHASE_SWING |-> hold_reg != 8'd0)
        else $error("swing phase with zero hold counter");

    a_prime_clears_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv3 && s2_reg.prime |=> result_valid && result.phase == gesd_pkg::PHASE_STANCE
            && result.hold_counter == 8'd0 && result.window_energy == 36'd0)
        else $error("prime beat left detector state in result");

    a_prime_clears_ring: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_prime |=> ring_valid_reg == '0)
        else $error("prime did not invalidate rate ring");

    a_pointers_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rate_ptr_reg <= RP_LAST && energy_ptr_reg <= EP_LAST)
        else $error("ring pointer out of range");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the gyro energy stance detector: a directed table, then
// gait-like random bursts over several register settings, checked against hand-worked
// results or a predictor. Depends on gesd_pkg and gyro_energy_stance_detector_top.
module tb_top;

    // Block geometry, kept equal to the instance parameters below.
    localparam int RATE_DEPTH   = 8;
    localparam int ENERGY_DEPTH = 16;
    localparam int MEAN_SHIFT   = 4;      // log2 of two IMUs times the ring depth
    localparam int DRAIN_SLACK  = 6;      // extra wait past the three-stage pipeline
    // No beat for this long means a hang: it covers the longest sender gap,
    // back-to-back receiver stalls and the pipeline, many times over.
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic signed [15:0] RATE_TOP    = 16'sh7FFF;
    localparam logic signed [15:0] RATE_BOTTOM = 16'sh8000;
    localparam logic [35:0]        THRESHOLD_TOP = 36'd51539607552;

    // Register settings for the random part, one per phase. The order matters: the
    // counter climbs under a huge hold, then the hold drops to zero below it, then a
    // huge threshold walks it back down to stance.
    localparam int PHASES = 6;
    localparam logic [35:0] SET_THRESHOLD [PHASES] =
        '{36'd0, 36'd0, 36'd0, THRESHOLD_TOP, 36'd200000000, gesd_pkg::THRESHOLD_RESET};
    localparam logic [7:0] SET_HOLD [PHASES] =
        '{8'd1, 8'd255, 8'd0, 8'd255, 8'd4, gesd_pkg::HOLD_COUNT_RESET};
    localparam int SET_ITEMS [PHASES] = '{150, 180, 120, 220, 150, 100};
    localparam bit SET_PRIMES [PHASES] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};

    localparam int DIRECTED_ROWS = 22;

    typedef enum logic [1:0] {BURST_QUIET, BURST_LOUD, BURST_PINNED} burst_kind_t;

    typedef struct packed {
        gesd_pkg::sample_t beat;
        logic              literal;     // want holds a result worked out by hand
        gesd_pkg::result_t want;
    } stim_row_t;

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              sample_valid = 1'b0;
    logic              sample_stall;
    gesd_pkg::sample_t sample       = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    gesd_pkg::result_t result;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [gesd_pkg::CFG_ADDR_W-1:0] paddr  = '0;
    logic [gesd_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [gesd_pkg::CFG_DATA_W-1:0] prdata;
    logic              pready;

    // Predictor state: a private copy of the detector and its registers.
    logic signed [16:0] rate_slot [RATE_DEPTH][3];
    logic signed [19:0] rate_acc [3];
    int unsigned        rate_wr;
    logic [31:0]        energy_hist [ENERGY_DEPTH];
    int unsigned        energy_wr;
    logic [35:0]        energy_acc;
    logic               gait;
    logic [7:0]         hold_cnt;
    logic [35:0]        cfg_threshold;
    logic [7:0]         cfg_hold;

    gesd_pkg::result_t awaited_results [$];
    gesd_pkg::result_t oldest;
    stim_row_t   directed_rows [DIRECTED_ROWS];
    int          fail_count      = 0;
    int          results_checked = 0;
    int          swing_results   = 0;
    int          beats_sent      = 0;
    int          beats_primed    = 0;
    int          idle_cycles     = 0;
    int          send_calm_left  = 0;
    int          stall_left      = 0;
    int          stall_calm_left = 0;
    int          stall_pick;

    gyro_energy_stance_detector_top #(
        .RATE_WINDOW   (RATE_DEPTH),
        .ENERGY_WINDOW (ENERGY_DEPTH),
        .SAMPLE_BITS   (16)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic gesd_pkg::sample_t mk_beat(input logic op,
                                                  input logic signed [15:0] ax, ay, az,
                                                  input logic signed [15:0] bx, by, bz);
        gesd_pkg::sample_t b;
        b.op       = op;
        b.gyro_a_x = ax;
        b.gyro_a_y = ay;
        b.gyro_a_z = az;
        b.gyro_b_x = bx;
        b.gyro_b_y = by;
        b.gyro_b_z = bz;
        return b;
    endfunction

    function automatic gesd_pkg::result_t mk_result(input logic ph, input logic [7:0] hold,
                                                    input logic signed [15:0] mx, my, mz,
                                                    input logic [35:0] energy);
        gesd_pkg::result_t r;
        r.phase         = ph;
        r.hold_counter  = hold;
        r.mean_rate_x   = mx;
        r.mean_rate_y   = my;
        r.mean_rate_z   = mz;
        r.window_energy = energy;
        return r;
    endfunction

    function automatic stim_row_t expect_row(input gesd_pkg::sample_t b,
                                             input gesd_pkg::result_t w);
        stim_row_t row;
        row.beat    = b;
        row.literal = 1'b1;
        row.want    = w;
        return row;
    endfunction

    function automatic stim_row_t predict_row(input gesd_pkg::sample_t b);
        stim_row_t row;
        row.beat    = b;
        row.literal = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    // Floor-divide a running sum by twice the ring depth and clamp to 16 bits.
    function automatic logic signed [15:0] window_mean(input logic signed [19:0] acc);
        logic signed [19:0] q;
        q = acc >>> MEAN_SHIFT;
        if (q > 20'sd32767)
            return RATE_TOP;
        if (q < -20'sd32768)
            return RATE_BOTTOM;
        return q[15:0];
    endfunction

    // Advance the private detector by one sample beat and return the result it yields.
    function automatic gesd_pkg::result_t track_gait(input gesd_pkg::sample_t b);
        logic signed [16:0] pair [3];
        logic signed [15:0] m [3];
        logic signed [31:0] sq;
        logic [31:0]        mag;
        logic               swing_seen;
        gesd_pkg::result_t  r;
        // Sum the two IMUs per axis at 17 bits.
        pair[0] = {b.gyro_a_x[15], b.gyro_a_x} + {b.gyro_b_x[15], b.gyro_b_x};
        pair[1] = {b.gyro_a_y[15], b.gyro_a_y} + {b.gyro_b_y[15], b.gyro_b_y};
        pair[2] = {b.gyro_a_z[15], b.gyro_a_z} + {b.gyro_b_z[15], b.gyro_b_z};
        if (b.op == gesd_pkg::OP_PRIME)
        begin
            // Fill the whole ring with this sample; keep the ring pointer.
            for (int ax = 0; ax < 3; ax++)
            begin
                for (int i = 0; i < RATE_DEPTH; i++)
                    rate_slot[i][ax] = pair[ax];
                rate_acc[ax] = 20'(pair[ax] * RATE_DEPTH);
                m[ax]        = window_mean(rate_acc[ax]);
            end
            for (int i = 0; i < ENERGY_DEPTH; i++)
                energy_hist[i] = '0;
            energy_wr       = 0;
            energy_acc      = '0;
            gait            = gesd_pkg::PHASE_STANCE;
            hold_cnt        = '0;
            r.window_energy = '0;
        end
        else
        begin
            mag = '0;
            for (int ax = 0; ax < 3; ax++)
            begin
                rate_acc[ax] = rate_acc[ax] + pair[ax] - rate_slot[rate_wr][ax];
                rate_slot[rate_wr][ax] = pair[ax];
                m[ax] = window_mean(rate_acc[ax]);
                sq    = m[ax] * m[ax];
                mag   = mag + sq;
            end
            rate_wr = (rate_wr + 1) % RATE_DEPTH;
            energy_acc = energy_acc - 36'(energy_hist[energy_wr]) + 36'(mag);
            energy_hist[energy_wr] = mag;
            energy_wr  = (energy_wr + 1) % ENERGY_DEPTH;
            swing_seen = (energy_acc >= cfg_threshold);
            // Move the counter only when the detection disagrees with the phase.
            if (swing_seen && gait == gesd_pkg::PHASE_STANCE)
            begin
                if (hold_cnt != gesd_pkg::HOLD_MAX)
                    hold_cnt = hold_cnt + 8'd1;
                gait = (hold_cnt >= cfg_hold) ? gesd_pkg::PHASE_SWING
                                              : gesd_pkg::PHASE_STANCE;
            end
            else if (!swing_seen && gait == gesd_pkg::PHASE_SWING)
            begin
                if (hold_cnt != 8'd0)
                    hold_cnt = hold_cnt - 8'd1;
                gait = (hold_cnt == 8'd0) ? gesd_pkg::PHASE_STANCE : gesd_pkg::PHASE_SWING;
            end
            r.window_energy = energy_acc;
        end
        r.phase        = gait;
        r.hold_counter = hold_cnt;
        r.mean_rate_x  = m[0];
        r.mean_rate_y  = m[1];
        r.mean_rate_z  = m[2];
        return r;
    endfunction

    // Offer one sample beat after a random gap; queue its result once it is taken.
    task automatic send_beat(input gesd_pkg::sample_t b, input gesd_pkg::result_t want);
        int gap;
        int r;
        gap = 0;
        if (send_calm_left > 0)
            send_calm_left--;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                send_calm_left = $urandom_range(40, 150);
            else if (r >= 55)
                gap = (r < 92) ? $urandom_range(1, 3) : $urandom_range(6, 24);
        end
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= b;
        // Hold the beat until an edge sees it with no stall.
        do @(posedge clk); while (sample_stall);
        awaited_results.push_back(want);
        beats_sent++;
    endtask

    // Drop valid and wait until every queued result has come back.
    task automatic drain_results();
        sample_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // One register write: setup cycle, then access until pready.
    task automatic write_reg(input logic [0:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (idx == gesd_pkg::REG_ENERGY_THRESHOLD)
            cfg_threshold = value[35:0];
        else
            cfg_hold = value[7:0];
    endtask

    function automatic void flag_field(input string field, input logic signed [63:0] want_v,
                                       input logic signed [63:0] got_v);
        if (fail_count < 40)
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
        fail_count++;
    endfunction

    // Stimulus: reset, the directed table, then the random phases.
    initial
    begin
        gesd_pkg::sample_t  b;
        gesd_pkg::result_t  want;
        logic signed [15:0] g [6];
        burst_kind_t        burst_kind;
        logic signed [15:0] pin_value;
        int                 burst_left;
        int                 r;
        int                 v;

        // Start the predictor from its reset state.
        for (int i = 0; i < RATE_DEPTH; i++)
            for (int ax = 0; ax < 3; ax++)
                rate_slot[i][ax] = '0;
        for (int i = 0; i < ENERGY_DEPTH; i++)
            energy_hist[i] = '0;
        for (int ax = 0; ax < 3; ax++)
            rate_acc[ax] = '0;
        rate_wr       = 0;
        energy_wr     = 0;
        energy_acc    = '0;
        gait          = gesd_pkg::PHASE_STANCE;
        hold_cnt      = '0;
        cfg_threshold = gesd_pkg::THRESHOLD_RESET;
        cfg_hold      = gesd_pkg::HOLD_COUNT_RESET;
        burst_left    = 0;
        burst_kind    = BURST_QUIET;
        pin_value     = RATE_TOP;

        // Directed table, run at the reset register values. Literal rows cover the
        // state after reset, both rails, prime, and the floor of a negative mean.
        directed_rows = '{
            expect_row(mk_beat(gesd_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0),
                       mk_result(gesd_pkg::PHASE_STANCE, 8'd0, 0, 0, 0, 36'd0)),
            expect_row(mk_beat(gesd_pkg::OP_PRIME, RATE_TOP, RATE_TOP, RATE_TOP,
                               RATE_TOP, RATE_TOP, RATE_TOP),
                       mk_result(gesd_pkg::PHASE_STANCE, 8'd0,
                                 RATE_TOP, RATE_TOP, RATE_TOP, 36'd0)),
            expect_row(mk_beat(gesd_pkg::OP_SAMPLE, RATE_TOP, RATE_TOP, RATE_TOP,
                               RATE_TOP, RATE_TOP, RATE_TOP),
                       mk_result(gesd_pkg::PHASE_STANCE, 8'd1,
                                 RATE_TOP, RATE_TOP, RATE_TOP, 36'd3221028867)),
            predict_row(mk_beat(gesd_pkg::OP_SAMPLE, RATE_TOP, RATE_TOP, RATE_TOP,
                                RATE_TOP, RATE_TOP, RATE_TOP)),
            predict_row(mk_beat(gesd_pkg::OP_SAMPLE, RATE_TOP, RATE_TOP, RATE_TOP,
                                RATE_TOP, RATE_TOP, RATE_TOP)),
            predict_row(mk_beat(gesd_pkg::OP_SAMPLE, RATE_TOP, RATE_TOP, RATE_TOP,
                                RATE_TOP, RATE_TOP, RATE_TOP)),
            // Fifth swing detection in a row reaches the hold count: switch to swing.
            expect_row(mk_beat(gesd_pkg::OP_SAMPLE, RATE_TOP, RATE_TOP, RATE_TOP,
                               RATE_TOP, RATE_TOP, RATE_TOP),
                       mk_result(gesd_pkg::PHASE_SWING, 8'd5,
                                 RATE_TOP, RATE_TOP, RATE_TOP, 36'd16105144335)),
            predict_row(mk_beat(gesd_pkg::OP_SAMPLE, RATE_TOP, RATE_TOP, RATE_TOP,
                                RATE_TOP, RATE_TOP, RATE_TOP)),
            expect_row(mk_beat(gesd_pkg::OP_PRIME, RATE_BOTTOM, RATE_BOTTOM, RATE_BOTTOM,
                               RATE_BOTTOM, RATE_BOTTOM, RATE_BOTTOM),
                       mk_result(gesd_pkg::PHASE_STANCE, 8'd0,
                                 RATE_BOTTOM, RATE_BOTTOM, RATE_BOTTOM, 36'd0)),
            expect_row(mk_beat(gesd_pkg::OP_SAMPLE, RATE_BOTTOM, RATE_BOTTOM, RATE_BOTTOM,
                               RATE_BOTTOM, RATE_BOTTOM, RATE_BOTTOM),
                       mk_result(gesd_pkg::PHASE_STANCE, 8'd1,
                                 RATE_BOTTOM, RATE_BOTTOM, RATE_BOTTOM, 36'd3221225472)),
            predict_row(mk_beat(gesd_pkg::OP_SAMPLE, RATE_TOP, RATE_TOP, RATE_TOP,
                                RATE_BOTTOM, RATE_BOTTOM, RATE_BOTTOM)),
            predict_row(mk_beat(gesd_pkg::OP_SAMPLE, 16'sh5555, 16'shAAAA, 16'sh00FF,
                                16'shAAAA, 16'sh5555, 16'shFF00)),
            predict_row(mk_beat(gesd_pkg::OP_SAMPLE, 16'shAAAA, 16'sh5555, 16'shFF00,
                                16'sh5555, 16'shAAAA, 16'sh00FF)),
            expect_row(mk_beat(gesd_pkg::OP_PRIME, 0, 0, 0, 0, 0, 0),
                       mk_result(gesd_pkg::PHASE_STANCE, 8'd0, 0, 0, 0, 36'd0)),
            predict_row(mk_beat(gesd_pkg::OP_SAMPLE, 3, -2, 1, -4, 5, 0)),
            predict_row(mk_beat(gesd_pkg::OP_SAMPLE, -120, 64, 7, 100, -90, -7)),
            predict_row(mk_beat(gesd_pkg::OP_SAMPLE, 1, 1, 1, 1, 1, 1)),
            predict_row(mk_beat(gesd_pkg::OP_SAMPLE, RATE_TOP, 0, 0, RATE_TOP, 0, 0)),
            predict_row(mk_beat(gesd_pkg::OP_SAMPLE, RATE_TOP, RATE_BOTTOM, 1,
                                RATE_TOP, RATE_BOTTOM, -1)),
            // Sum of minus one over the ring floors to a mean of minus one.
            expect_row(mk_beat(gesd_pkg::OP_PRIME, -1, -1, -1, 0, 0, 0),
                       mk_result(gesd_pkg::PHASE_STANCE, 8'd0, -1, -1, -1, 36'd0)),
            predict_row(mk_beat(gesd_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0)),
            predict_row(mk_beat(gesd_pkg::OP_SAMPLE, RATE_BOTTOM, RATE_BOTTOM, RATE_BOTTOM,
                                RATE_BOTTOM, RATE_BOTTOM, RATE_BOTTOM))
        };

        // Hold reset, then release it once.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            want = track_gait(directed_rows[i].beat);
            if (directed_rows[i].literal)
                want = directed_rows[i].want;
            if (directed_rows[i].beat.op == gesd_pkg::OP_PRIME)
                beats_primed++;
            send_beat(directed_rows[i].beat, want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            // Registers change only with the pipeline empty.
            drain_results();
            write_reg(gesd_pkg::REG_ENERGY_THRESHOLD, 64'(SET_THRESHOLD[p]));
            write_reg(gesd_pkg::REG_HOLD_COUNT, 64'(SET_HOLD[p]));
            for (int n = 0; n < SET_ITEMS[p]; n++)
            begin
                // Walk a gait: quiet stance stretches, loud swing stretches, and
                // pinned runs long enough to fill both windows at a rail.
                if (burst_left == 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 45)
                        burst_kind = BURST_QUIET;
                    else if (r < 92)
                        burst_kind = BURST_LOUD;
                    else
                        burst_kind = BURST_PINNED;
                    burst_left = (burst_kind == BURST_PINNED) ? $urandom_range(20, 40)
                                                              : $urandom_range(3, 40);
                    pin_value  = $urandom_range(0, 1) ? RATE_BOTTOM : RATE_TOP;
                end
                burst_left--;
                r = $urandom_range(0, 99);
                for (int i = 0; i < 6; i++)
                begin
                    v = $urandom_range(0, 600);
                    if (burst_kind == BURST_PINNED)
                        g[i] = pin_value;
                    else if (burst_kind == BURST_LOUD || (r >= 3 && r < 11))
                        g[i] = 16'($urandom);    // full range, also the noise beats
                    else
                        g[i] = 16'(v - 300);
                end
                b = mk_beat((SET_PRIMES[p] && r < 3) ? gesd_pkg::OP_PRIME
                                                     : gesd_pkg::OP_SAMPLE,
                            g[0], g[1], g[2], g[3], g[4], g[5]);
                if (b.op == gesd_pkg::OP_PRIME)
                    beats_primed++;
                send_beat(b, track_gait(b));
                // Once mid-phase, stop sending until the block has emptied.
                if (p == 4 && n == SET_ITEMS[p] / 2)
                    drain_results();
            end
        end

        drain_results();
        $display("Covered %0d sample beats (%0d directed, %0d primes) over %0d register settings.",
                 beats_sent, DIRECTED_ROWS, beats_primed, PHASES + 1);
        $display("Checked %0d result beats, %0d of them in swing; %0d mismatches.",
                 results_checked, swing_results, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Result stall: short stalls, a few long ones, and calm stretches with none.
    always @(posedge clk)
    begin
        if (stall_calm_left > 0)
        begin
            stall_calm_left--;
            result_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 4)
                stall_calm_left = $urandom_range(50, 200);
            else if (stall_pick < 27)
                stall_left = $urandom_range(0, 2);
            else if (stall_pick < 30)
                stall_left = $urandom_range(10, 30);
            result_stall <= (stall_pick >= 4 && stall_pick < 30);
        end
    end

    // Compare each taken result beat with the oldest queued result.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_checked++;
            if (result.phase == gesd_pkg::PHASE_SWING)
                swing_results++;
            if (awaited_results.size() == 0)
            begin
                if (fail_count < 40)
                    $error("result beat arrived with none outstanding");
                fail_count++;
            end
            else
            begin
                oldest = awaited_results.pop_front();
                if (result.phase !== oldest.phase)
                    flag_field("phase", oldest.phase, result.phase);
                if (result.hold_counter !== oldest.hold_counter)
                    flag_field("hold_counter", oldest.hold_counter, result.hold_counter);
                if (result.mean_rate_x !== oldest.mean_rate_x)
                    flag_field("mean_rate_x", oldest.mean_rate_x, result.mean_rate_x);
                if (result.mean_rate_y !== oldest.mean_rate_y)
                    flag_field("mean_rate_y", oldest.mean_rate_y, result.mean_rate_y);
                if (result.mean_rate_z !== oldest.mean_rate_z)
                    flag_field("mean_rate_z", oldest.mean_rate_z, result.mean_rate_z);
                if (result.window_energy !== oldest.window_energy)
                    flag_field("window_energy", oldest.window_energy, result.window_energy);
            end
        end
    end

    // Watchdog: end the run if neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat for %0d cycles, %0d results outstanding.",
                     WATCHDOG_LIMIT, awaited_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
